@@ design/tsph_pkg.sv @@
`default_nettype none
package tsph_pkg;

  typedef enum logic [3:0] {
    PH_HDR      = 4'd0,
    PH_AFLEN    = 4'd1,
    PH_FLAGS    = 4'd2,
    PH_PCR      = 4'd3,
    PH_OPCR     = 4'd4,
    PH_SPLICE   = 4'd5,
    PH_PRIVLEN  = 4'd6,
    PH_PRIV     = 4'd7,
    PH_EXTLEN   = 4'd8,
    PH_EXTFLAGS = 4'd9,
    PH_LTW      = 4'd10,
    PH_RATE     = 4'd11,
    PH_DTS      = 4'd12,
    PH_DONE     = 4'd13
  } phase_t;

  typedef enum logic [3:0] {
    RK_HEADER  = 4'd0,
    RK_AFLEN   = 4'd1,
    RK_AFFLAGS = 4'd2,
    RK_PCR     = 4'd3,
    RK_OPCR    = 4'd4,
    RK_SPLICE  = 4'd5,
    RK_PRIVLEN = 4'd6,
    RK_PRIVBYT = 4'd7,
    RK_EXTLEN  = 4'd8,
    RK_LTW     = 4'd9,
    RK_RATE    = 4'd10,
    RK_DTS     = 4'd11,
    RK_PAYOFF  = 4'd12,
    RK_END     = 4'd13
  } kind_t;

  // One result record as it leaves the block.
  typedef struct packed {
    logic        last;
    logic [7:0]  idx;
    logic [41:0] value;
    kind_t       kind;
  } record_t;

  localparam int unsigned ClockScale = 300;

endpackage
`default_nettype wire

@@ design/ts_packet_header_parser.sv @@
// Channel | Side   | tdata                                  | tuser       | tlast
// in_     | slave  | [7:0] packet_byte                      | packet_start| -
// out_    | master | [41:0] value, [49:42] idx, zero fill   | [3:0] kind  | last_record
// A byte accepted at the input sits in the input register and is parsed by one
// pass of field logic once the queue has room; its records (up to two) are then
// registered into a four-entry output queue. One byte per cycle is taken while
// the queue holds at most two records; otherwise the byte waits in the input
// register and in_tready stays low until the queue drains. Reset is synchronous
// and clears control state only; the first byte after reset starts a packet.
`default_nettype none
module ts_packet_header_parser #(
  parameter int unsigned PACKET_BYTES = 188
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] packet_byte
  input  wire logic        in_tuser,   // [0] packet_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [41:0] record_value, [49:42] byte_index,
                                       // zero fill
  output logic [3:0]       out_tuser,  // [3:0] record_kind
  output logic             out_tlast   // last_record
);
  import tsph_pkg::*;

  // Input register stage.
  logic       iv_r;
  logic [7:0] ib_r;
  logic       is_r;

  // Parser state.
  logic [7:0]  pos_r;
  phase_t      ph_r;
  logic [7:0]  left_r;
  logic [7:0]  aflags_r;
  logic [7:0]  eflags_r;
  logic [7:0]  pcnt_r;
  logic [47:0] acc_r;
  logic [23:0] hdr_r;

  // Output queue, four entries.
  record_t     q_r [4];
  logic [2:0]  qn_r;
  logic [1:0]  qh_r;
  logic [1:0]  qt;

  logic        in_acc, out_acc, fire;
  logic [1:0]  nrec;
  record_t     r0, r1;

  // Parser next values.
  logic [7:0]  p, pos_nxt, left_nxt, aflags_nxt, eflags_nxt, pcnt_nxt;
  phase_t      ph_nxt;
  logic [47:0] acc_nxt, a;
  logic [23:0] hdr_nxt;
  logic [42:0] clk_val;
  logic [32:0] dts;
  logic        adv;
  phase_t      adv_from, nph;
  logic [7:0]  flags_for_adv;

  // The registered byte is parsed only when the queue has room for two records.
  assign fire       = iv_r && (qn_r <= 3'd2);
  assign in_tready  = !iv_r || fire;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (qn_r != 3'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign qt         = qh_r + qn_r[1:0];
  assign out_tdata  = {6'b0, q_r[qh_r].idx, q_r[qh_r].value};
  assign out_tuser  = q_r[qh_r].kind;
  assign out_tlast  = q_r[qh_r].last;

  // Input register: holds a byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_acc) begin
      iv_r <= 1'b1;
    end else if (fire) begin
      iv_r <= 1'b0;
    end
    if (in_acc) begin
      ib_r <= in_tdata;
      is_r <= in_tuser;
    end
  end

  // Next present field after a given phase.
  function automatic phase_t next_phase(phase_t from, logic [7:0] af,
                                        logic [7:0] ef, logic [7:0] plen);
    phase_t r;
    r = PH_DONE;
    for (int k = 12; k >= 3; k--) begin
      if (k > int'(from)) begin
        case (k)
          3:  if (af[4]) r = PH_PCR;
          4:  if (af[3]) r = PH_OPCR;
          5:  if (af[2]) r = PH_SPLICE;
          6:  if (af[1]) r = PH_PRIVLEN;
          7:  if (af[1] && plen != 8'd0) r = PH_PRIV;
          8:  if (af[0]) r = PH_EXTLEN;
          9:  if (af[0]) r = PH_EXTFLAGS;
          10: if (ef[7]) r = PH_LTW;
          11: if (ef[6]) r = PH_RATE;
          12: if (ef[5]) r = PH_DTS;
          default: r = r;
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] phase_len(phase_t ph, logic [7:0] plen);
    case (ph)
      PH_PCR, PH_OPCR: return 8'd6;
      PH_PRIV:         return plen;
      PH_LTW:          return 8'd2;
      PH_RATE:         return 8'd3;
      PH_DTS:          return 8'd5;
      PH_DONE:         return 8'd0;
      default:         return 8'd1;
    endcase
  endfunction

  // One pass of field logic on the registered byte.
  always_comb begin
    p = is_r ? 8'd0 : pos_r;
    if (32'(p) >= PACKET_BYTES) p = 8'd0;
    pos_nxt = (32'(p) + 1 >= PACKET_BYTES) ? 8'd0 : p + 8'd1;
    ph_nxt = ph_r; left_nxt = left_r; aflags_nxt = aflags_r;
    eflags_nxt = eflags_r; pcnt_nxt = pcnt_r; acc_nxt = acc_r; hdr_nxt = hdr_r;
    nrec = 2'd0;
    r0 = '{last: 1'b0, idx: 8'd0, value: 42'd0, kind: RK_END};
    r1 = r0;
    adv = 1'b0; adv_from = ph_r;
    a = {acc_r[39:0], ib_r};
    clk_val = 43'({10'd0, a[47:15]} * 43'(ClockScale)) + 43'(a[8:0]);
    dts = {a[35:33], a[31:17], a[15:1]};
    if (p == 8'd0) begin
      ph_nxt = PH_HDR; left_nxt = 8'd0; aflags_nxt = 8'd0; eflags_nxt = 8'd0;
      pcnt_nxt = 8'd0; acc_nxt = 48'd0; hdr_nxt = 24'd0;
    end else if (p <= 8'd3) begin
      hdr_nxt = {hdr_r[15:0], ib_r};
      if (p == 8'd3) begin
        r0.kind = RK_HEADER; r0.value = 42'(hdr_nxt);
        if (hdr_nxt[5]) begin
          ph_nxt = PH_AFLEN; nrec = 2'd1;
        end else begin
          ph_nxt = PH_DONE; nrec = 2'd2;
          r1.kind = RK_PAYOFF; r1.value = 42'd4;
        end
      end
    end else if (ph_r == PH_AFLEN) begin
      r0.kind = RK_AFLEN; r0.value = 42'(ib_r); nrec = 2'd1;
      if (9'd5 + 9'(ib_r) <= 9'(PACKET_BYTES)) begin
        r1.kind = RK_PAYOFF; r1.value = 42'(9'd5 + 9'(ib_r)); nrec = 2'd2;
      end
      ph_nxt = (ib_r == 8'd0) ? PH_DONE : PH_FLAGS;
    end else if (ph_r == PH_FLAGS) begin
      aflags_nxt = ib_r;
      r0.kind = RK_AFFLAGS; r0.value = 42'(ib_r); nrec = 2'd1;
      adv = 1'b1;
    end else if (ph_r == PH_PRIV) begin
      r0.kind = RK_PRIVBYT; r0.value = 42'(ib_r); r0.idx = pcnt_r; nrec = 2'd1;
      pcnt_nxt = pcnt_r + 8'd1;
      if (left_r <= 8'd1) adv = 1'b1;
      else left_nxt = left_r - 8'd1;
    end else if (ph_r > PH_FLAGS && ph_r < PH_DONE) begin
      acc_nxt = a;
      if (left_r > 8'd1) begin
        left_nxt = left_r - 8'd1;
      end else begin
        adv = 1'b1; nrec = 2'd1;
        case (ph_r)
          PH_PCR:    begin r0.kind = RK_PCR;    r0.value = clk_val[41:0]; end
          PH_OPCR:   begin r0.kind = RK_OPCR;   r0.value = clk_val[41:0]; end
          PH_SPLICE: begin r0.kind = RK_SPLICE; r0.value = 42'(a[7:0]); end
          PH_PRIVLEN: begin
            r0.kind = RK_PRIVLEN; r0.value = 42'(a[7:0]); pcnt_nxt = 8'd0;
          end
          PH_EXTLEN: begin r0.kind = RK_EXTLEN; r0.value = 42'(a[7:0]); end
          PH_EXTFLAGS: begin eflags_nxt = a[7:0]; nrec = 2'd0; end
          PH_LTW:    begin r0.kind = RK_LTW;  r0.value = 42'(a[15:0]); end
          PH_RATE:   begin r0.kind = RK_RATE; r0.value = 42'(a[21:0]); end
          default: begin
            r0.kind = RK_DTS; r0.value = 42'({a[39:36], dts});
          end
        endcase
      end
    end
    // Advance to the next present field; the private length is in a[7:0].
    flags_for_adv = (adv_from == PH_FLAGS) ? ib_r : aflags_r;
    nph = next_phase(adv_from, flags_for_adv, eflags_nxt, a[7:0]);
    if (adv) begin
      ph_nxt = nph; left_nxt = phase_len(nph, a[7:0]); acc_nxt = 48'd0;
    end
    // End of packet record.
    if (32'(p) == PACKET_BYTES - 1) begin
      ph_nxt = PH_DONE;
      if (nrec == 2'd0) begin
        r0 = '{last: 1'b1, idx: 8'd0, value: 42'd0, kind: RK_END}; nrec = 2'd1;
      end else begin
        r1 = '{last: 1'b1, idx: 8'd0, value: 42'd0, kind: RK_END}; nrec = 2'd2;
      end
    end
  end

  // Parser state update and queue bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 8'd0; ph_r <= PH_HDR; left_r <= 8'd0; aflags_r <= 8'd0;
      eflags_r <= 8'd0; pcnt_r <= 8'd0; acc_r <= 48'd0; hdr_r <= 24'd0;
      qn_r <= 3'd0; qh_r <= 2'd0;
    end else begin
      if (fire) begin
        pos_r <= pos_nxt; ph_r <= ph_nxt; left_r <= left_nxt;
        aflags_r <= aflags_nxt; eflags_r <= eflags_nxt; pcnt_r <= pcnt_nxt;
        acc_r <= acc_nxt; hdr_r <= hdr_nxt;
      end
      qn_r <= qn_r + (fire ? 3'(nrec) : 3'd0) - (out_acc ? 3'd1 : 3'd0);
      if (out_acc) qh_r <= qh_r + 2'd1;
    end
  end

  // Queue entries: new records go in behind the ones still waiting.
  always_ff @(posedge clk) begin
    if (fire && nrec != 2'd0) q_r[qt] <= r0;
    if (fire && nrec == 2'd2) q_r[qt + 2'd1] <= r1;
  end

endmodule
`default_nettype wire
